@@ src/ilfc_pkg.sv @@
// Shared types, codes and keyword tables for the IRC line field classifier.
package ilfc_pkg;

   // Number of middle parameters at which a line is typed unknown.
   localparam int MAX_PARAMS = 15;

   // Widths of the result fields.
   localparam int TAG_W   = 3;
   localparam int INDEX_W = 4;
   localparam int MTYPE_W = 3;
   localparam int COUNT_W = 5;

   // Field tags given to each byte.
   localparam logic [TAG_W-1:0] TAG_DROP    = 3'd0;
   localparam logic [TAG_W-1:0] TAG_NICK    = 3'd1;
   localparam logic [TAG_W-1:0] TAG_USER    = 3'd2;
   localparam logic [TAG_W-1:0] TAG_HOST    = 3'd3;
   localparam logic [TAG_W-1:0] TAG_COMMAND = 3'd4;
   localparam logic [TAG_W-1:0] TAG_PARAM   = 3'd5;
   localparam logic [TAG_W-1:0] TAG_TRAIL   = 3'd6;

   // Message types reported at end of line.
   localparam logic [MTYPE_W-1:0] MTYPE_MESSAGE = 3'd0;
   localparam logic [MTYPE_W-1:0] MTYPE_PING    = 3'd1;
   localparam logic [MTYPE_W-1:0] MTYPE_NOTICE  = 3'd2;
   localparam logic [MTYPE_W-1:0] MTYPE_ERROR   = 3'd3;
   localparam logic [MTYPE_W-1:0] MTYPE_UNKNOWN = 3'd4;

   // Character codes the parser looks for.
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [7:0] CHAR_AT    = 8'h40;

   // Parse phases of a line.
   typedef enum logic [2:0] {
      PH_START       = 3'd0,
      PH_PREFIX_LEAD = 3'd1,
      PH_PREFIX      = 3'd2,
      PH_CMD_LEAD    = 3'd3,
      PH_CMD         = 3'd4,
      PH_MID_START   = 3'd5,
      PH_PARAMS      = 3'd6,
      PH_TRAIL       = 3'd7
   } phase_type;

   // Part of the prefix being filled.
   typedef enum logic [1:0] {
      SUB_NICK = 2'd0,
      SUB_USER = 2'd1,
      SUB_HOST = 2'd2
   } subfield_type;

   // Keyword that has matched in full; the code equals the message type.
   typedef enum logic [1:0] {
      KW_NONE   = 2'd0,
      KW_PING   = 2'd1,
      KW_NOTICE = 2'd2,
      KW_ERROR  = 2'd3
   } keyword_type;

   // Keyword texts and lengths, candidate bit 0 PING, 1 NOTICE, 2 ERROR.
   localparam int KW_COUNT = 3;
   localparam logic [0:5][7:0]  KW_PING_TEXT   = "PING :";
   localparam logic [0:12][7:0] KW_NOTICE_TEXT = "NOTICE AUTH :";
   localparam logic [0:6][7:0]  KW_ERROR_TEXT  = "ERROR :";
   localparam logic [3:0] KW_PING_LEN   = 4'd6;
   localparam logic [3:0] KW_NOTICE_LEN = 4'd13;
   localparam logic [3:0] KW_ERROR_LEN  = 4'd7;

   // Length of keyword k.
   function automatic logic [3:0] kw_len(input logic [1:0] k);
      logic [3:0] len;
      case (k)
         2'd0:    len = KW_PING_LEN;
         2'd1:    len = KW_NOTICE_LEN;
         default: len = KW_ERROR_LEN;
      endcase
      return len;
   endfunction

   // Character of keyword k at position pos; only called with pos below its length.
   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [3:0] pos);
      logic [7:0] ch;
      case (k)
         2'd0:    ch = KW_PING_TEXT[pos[2:0]];
         2'd1:    ch = KW_NOTICE_TEXT[pos];
         default: ch = KW_ERROR_TEXT[pos[2:0]];
      endcase
      return ch;
   endfunction

endpackage

@@ src/ilfc_kw_match.sv @@
// Keyword tracker that spots lines opening with PING, NOTICE AUTH or ERROR.
module ilfc_kw_match (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,        // one byte is processed this cycle
   input  logic [7:0]          line_byte,
   input  logic                end_of_line,
   output ilfc_pkg::keyword_type matched    // keyword complete, including this byte
);

   logic [3:0] pos_ff, pos_in;
   logic [ilfc_pkg::KW_COUNT-1:0] cand_ff, cand_in, cand_next;
   logic [3:0] pos_next;

   // Drop candidates that disagree with this byte, then see which has completed.
   always_comb begin
      cand_next = cand_ff;
      for (int k = 0; k < ilfc_pkg::KW_COUNT; k++) begin
         if (cand_ff[k] && (pos_ff < ilfc_pkg::kw_len(2'(k))) &&
             (line_byte != ilfc_pkg::kw_char(2'(k), pos_ff))) begin
            cand_next[k] = 1'b0;
         end
      end
      pos_next = (pos_ff == 4'd15) ? pos_ff : pos_ff + 4'd1;
      matched = ilfc_pkg::KW_NONE;
      if (cand_next[0] && pos_next >= ilfc_pkg::KW_PING_LEN) begin
         matched = ilfc_pkg::KW_PING;
      end
      if (cand_next[1] && pos_next >= ilfc_pkg::KW_NOTICE_LEN) begin
         matched = ilfc_pkg::KW_NOTICE;
      end
      if (cand_next[2] && pos_next >= ilfc_pkg::KW_ERROR_LEN) begin
         matched = ilfc_pkg::KW_ERROR;
      end
   end

   // Next state: restart at end of line.
   always_comb begin
      pos_in  = pos_ff;
      cand_in = cand_ff;
      if (step) begin
         if (end_of_line) begin
            pos_in  = 4'd0;
            cand_in = '1;
         end else begin
            pos_in  = pos_next;
            cand_in = cand_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 4'd0;
         cand_ff <= '1;
      end else begin
         pos_ff  <= pos_in;
         cand_ff <= cand_in;
      end
   end

   // A completed NOTICE keyword has its position at or past its length.
   assert property (@(posedge clock) disable iff (reset)
      (matched == ilfc_pkg::KW_NOTICE) |-> (pos_next >= ilfc_pkg::KW_NOTICE_LEN))
      else $error("NOTICE match reported too early");

   // After end of line the tracker starts over with every candidate live.
   assert property (@(posedge clock) disable iff (reset)
      (step && end_of_line) |=> (pos_ff == 4'd0 && cand_ff == '1))
      else $error("keyword tracker not restarted after end of line");

   // The position never moves when no byte is processed.
   assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(pos_ff))
      else $error("keyword position moved without a byte");

endmodule

@@ src/irc_line_field_classifier.sv @@
// Top level of the IRC line field classifier: input stage, parser and result register.
//
// Usage: a raw IRC line (no CR LF) enters one byte per word on the req_ channel,
// req_tlast set on the last byte. Every byte gives exactly one result word on
// the rsp_ channel carrying its field tag (rsp_tuser) and, for middle
// parameters, the parameter index. The word for the last byte has rsp_tlast
// set and also carries the message type, the nick!user@host flag and the
// parameter count; on other words those summary fields are zero.
// An accepted byte is first held in the input register; its result word is
// then registered in the result register. Throughput is one byte per cycle
// while the receiver takes results, set by the single registered pass of
// parser and keyword tracker between the input and result registers.
// Reset (synchronous, active high) empties both registers and returns the
// parser to the start of a line. When the receiver holds rsp_tready low the
// result register keeps its word, the input register can still take one
// more byte, and then req_tready drops until the result is taken.
module irc_line_field_classifier (
   input  logic        clock,
   input  logic        reset,
   // Input channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] line_byte
   input  logic        req_tlast,   // end_of_line
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [3:0] param_index, [6:4] message_type,
                                    // [7] has_user_host, [12:8] param_count, [15:13] zero
   output logic [2:0]  rsp_tuser,   // [2:0] field_tag
   output logic        rsp_tlast    // line_done
);

   // Input stage.
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;
   logic       advance;

   // Parser state.
   ilfc_pkg::phase_type    phase_ff, phase_in;
   ilfc_pkg::subfield_type sub_ff, sub_in;
   logic [ilfc_pkg::COUNT_W-1:0] seen_ff, seen_in, seen_m1;
   logic       in_tok_ff, in_tok_in;
   logic [2:0] nonempty_ff, nonempty_in;
   logic       ovf_ff, ovf_in;

   // Result register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ilfc_pkg::TAG_W-1:0]     tag_ff, tag_in;
   logic [ilfc_pkg::INDEX_W-1:0]   idx_ff, idx_in;
   logic                           done_ff, done_in;
   logic [ilfc_pkg::MTYPE_W-1:0]   mtype_ff, mtype_in;
   logic                           uh_ff, uh_in;
   logic [ilfc_pkg::COUNT_W-1:0]   cnt_ff, cnt_in;

   ilfc_pkg::keyword_type matched;
   logic do_prefix;
   logic do_params;

   // A byte moves on when the result register is empty or being emptied.
   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || advance;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   ilfc_kw_match u_kw_match (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .line_byte   (s1_byte_ff),
      .end_of_line (s1_last_ff),
      .matched     (matched)
   );

   assign seen_m1 = seen_ff - ilfc_pkg::COUNT_W'(1);

   // Classify the byte in the input register and work out the next parser state.
   always_comb begin
      phase_in    = phase_ff;
      sub_in      = sub_ff;
      seen_in     = seen_ff;
      in_tok_in   = in_tok_ff;
      nonempty_in = nonempty_ff;
      ovf_in      = ovf_ff;
      tag_in      = ilfc_pkg::TAG_DROP;
      idx_in      = '0;
      done_in     = 1'b0;
      mtype_in    = ilfc_pkg::MTYPE_MESSAGE;
      uh_in       = 1'b0;
      cnt_in      = '0;
      do_prefix   = 1'b0;
      do_params   = 1'b0;

      // Phase walk.
      case (phase_ff)
         ilfc_pkg::PH_START: begin
            phase_in = ilfc_pkg::PH_PREFIX_LEAD;
         end
         ilfc_pkg::PH_PREFIX_LEAD: begin
            if (s1_byte_ff != ilfc_pkg::CHAR_SPACE) begin
               phase_in  = ilfc_pkg::PH_PREFIX;
               do_prefix = 1'b1;
            end
         end
         ilfc_pkg::PH_PREFIX: begin
            if (s1_byte_ff == ilfc_pkg::CHAR_SPACE) begin
               phase_in = ilfc_pkg::PH_CMD_LEAD;
            end else begin
               do_prefix = 1'b1;
            end
         end
         ilfc_pkg::PH_CMD_LEAD: begin
            if (s1_byte_ff != ilfc_pkg::CHAR_SPACE) begin
               phase_in = ilfc_pkg::PH_CMD;
               tag_in   = ilfc_pkg::TAG_COMMAND;
            end
         end
         ilfc_pkg::PH_CMD: begin
            if (s1_byte_ff == ilfc_pkg::CHAR_SPACE) begin
               phase_in = ilfc_pkg::PH_MID_START;
            end else begin
               tag_in = ilfc_pkg::TAG_COMMAND;
            end
         end
         ilfc_pkg::PH_MID_START: begin
            phase_in  = ilfc_pkg::PH_PARAMS;
            do_params = 1'b1;
         end
         ilfc_pkg::PH_PARAMS: begin
            do_params = 1'b1;
         end
         default: begin
            tag_in = ilfc_pkg::TAG_TRAIL;
         end
      endcase

      // Prefix split into nick, user and host.
      if (do_prefix) begin
         case (sub_ff)
            ilfc_pkg::SUB_NICK: begin
               if (s1_byte_ff == ilfc_pkg::CHAR_BANG) begin
                  if (nonempty_ff[0]) begin
                     sub_in = ilfc_pkg::SUB_USER;
                  end
               end else begin
                  nonempty_in[0] = 1'b1;
                  tag_in         = ilfc_pkg::TAG_NICK;
               end
            end
            ilfc_pkg::SUB_USER: begin
               if (s1_byte_ff == ilfc_pkg::CHAR_AT) begin
                  if (nonempty_ff[1]) begin
                     sub_in = ilfc_pkg::SUB_HOST;
                  end
               end else begin
                  nonempty_in[1] = 1'b1;
                  tag_in         = ilfc_pkg::TAG_USER;
               end
            end
            default: begin
               nonempty_in[2] = 1'b1;
               tag_in         = ilfc_pkg::TAG_HOST;
            end
         endcase
      end

      // Middle parameters and the colon that opens the trailing part.
      if (do_params) begin
         if (s1_byte_ff == ilfc_pkg::CHAR_SPACE) begin
            in_tok_in = 1'b0;
         end else if (in_tok_ff) begin
            idx_in = seen_m1[ilfc_pkg::INDEX_W-1:0];
            tag_in = ilfc_pkg::TAG_PARAM;
         end else if (ovf_ff) begin
            tag_in = ilfc_pkg::TAG_DROP;
         end else if (s1_byte_ff == ilfc_pkg::CHAR_COLON) begin
            phase_in = ilfc_pkg::PH_TRAIL;
         end else begin
            seen_in   = seen_ff + ilfc_pkg::COUNT_W'(1);
            in_tok_in = 1'b1;
            if (seen_in >= ilfc_pkg::COUNT_W'(ilfc_pkg::MAX_PARAMS)) begin
               ovf_in = 1'b1;
            end
            idx_in = seen_ff[ilfc_pkg::INDEX_W-1:0];
            tag_in = ilfc_pkg::TAG_PARAM;
         end
      end

      // A completed keyword drops the byte.
      if (matched != ilfc_pkg::KW_NONE) begin
         tag_in = ilfc_pkg::TAG_DROP;
         idx_in = '0;
      end

      // Line summary, then back to the start of a line.
      if (s1_last_ff) begin
         done_in = 1'b1;
         if (matched != ilfc_pkg::KW_NONE) begin
            mtype_in = {1'b0, matched};
         end else if (phase_in < ilfc_pkg::PH_PARAMS) begin
            mtype_in = ilfc_pkg::MTYPE_UNKNOWN;
         end else begin
            uh_in    = (nonempty_in == 3'b111);
            cnt_in   = seen_in;
            mtype_in = ovf_in ? ilfc_pkg::MTYPE_UNKNOWN : ilfc_pkg::MTYPE_MESSAGE;
         end
         phase_in    = ilfc_pkg::PH_START;
         sub_in      = ilfc_pkg::SUB_NICK;
         seen_in     = '0;
         in_tok_in   = 1'b0;
         nonempty_in = '0;
         ovf_in      = 1'b0;
      end
   end

   // Parser state advances with each processed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= ilfc_pkg::PH_START;
         sub_ff      <= ilfc_pkg::SUB_NICK;
         seen_ff     <= '0;
         in_tok_ff   <= 1'b0;
         nonempty_ff <= '0;
         ovf_ff      <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         sub_ff      <= sub_in;
         seen_ff     <= seen_in;
         in_tok_ff   <= in_tok_in;
         nonempty_ff <= nonempty_in;
         ovf_ff      <= ovf_in;
      end
   end

   // Result register.
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff   <= tag_in;
         idx_ff   <= idx_in;
         done_ff  <= done_in;
         mtype_ff <= mtype_in;
         uh_ff    <= uh_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = tag_ff;
   assign rsp_tlast  = done_ff;
   assign rsp_tdata  = {3'b000, cnt_ff, uh_ff, mtype_ff, idx_ff};

   // The parameter count never passes the limit.
   assert property (@(posedge clock) disable iff (reset)
      seen_ff <= ilfc_pkg::COUNT_W'(ilfc_pkg::MAX_PARAMS))
      else $error("parameter count past limit");

   // Overflow is set exactly when the count has reached the limit.
   assert property (@(posedge clock) disable iff (reset)
      ovf_ff == (seen_ff == ilfc_pkg::COUNT_W'(ilfc_pkg::MAX_PARAMS)))
      else $error("overflow flag and parameter count disagree");

   // Summary fields are zero on words that do not end a line.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !done_ff) |-> (mtype_ff == '0 && !uh_ff && cnt_ff == '0))
      else $error("summary fields set before end of line");

   // Only middle-parameter bytes carry a parameter index.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && tag_ff != ilfc_pkg::TAG_PARAM) |-> (idx_ff == '0))
      else $error("parameter index on a byte that is no parameter");

   // A byte in the input register waits there until it is processed.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff)
      else $error("input byte lost while the result register was full");

endmodule
